/* src/kls_pkg.sv */
// Shared types and widths for the k-th largest stream tracker.
`default_nettype none

package kls_pkg;

  // Fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned RankW  = 5;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic        [RankW-1:0]  rank_t;

  // Result handed from the pick stage to the output register
  typedef struct packed {
    logic   short_set;
    value_t kth_value;
  } kls_result_t;

endpackage

`default_nettype wire

/* src/kls_row.sv */
// Sorted register row of kept values with its fill count and registered update.
`default_nettype none

module kls_row
  import kls_pkg::*;
#(
  parameter int unsigned K_MAX = 16,
  localparam int unsigned CntW = $clog2(K_MAX + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            upd_en_i,
  input  wire value_t          value_i,
  input  wire logic            last_i,
  input  wire logic [CntW-1:0] k_i,
  output value_t               row_d_o [K_MAX],
  output logic      [CntW-1:0] cnt_d_o
);

  value_t          row_q [K_MAX];
  value_t          row_d [K_MAX];
  value_t          row_prev [K_MAX];
  value_t          row_next [K_MAX];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic [K_MAX-1:0] valid;
  logic [K_MAX-1:0] gt;
  logic [K_MAX-1:0] lt;
  logic [K_MAX-1:0] gt_prev;
  logic [K_MAX-1:0] lt_next;
  logic            do_ins;
  logic            do_rep;

  // Compare the new value against every kept entry in parallel
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      valid[i] = (CntW'(i) < cnt_q);
      gt[i]    = valid[i] && (row_q[i] > value_i);
      lt[i]    = valid[i] && (row_q[i] < value_i);
    end
    gt_prev[0]  = 1'b0;
    row_prev[0] = row_q[0];
    for (int i = 1; i < K_MAX; i++) begin
      gt_prev[i]  = gt[i-1];
      row_prev[i] = row_q[i-1];
    end
    lt_next[K_MAX-1]  = 1'b0;
    row_next[K_MAX-1] = row_q[K_MAX-1];
    for (int i = 0; i < K_MAX - 1; i++) begin
      lt_next[i]  = lt[i+1];
      row_next[i] = row_q[i+1];
    end
  end

  // Pick insert, replace-smallest or hold
  always_comb begin
    do_ins = (cnt_q < k_i) && (cnt_q < CntW'(K_MAX));
    do_rep = !do_ins && (cnt_q != '0) && (value_i >= row_q[0]);
    cnt_d  = do_ins ? cnt_q + CntW'(1) : cnt_q;
    for (int i = 0; i < K_MAX; i++) begin
      if (do_ins) begin
        // shift larger entries up one place, drop the value into the gap
        if (gt_prev[i]) begin
          row_d[i] = row_prev[i];
        end else if (gt[i] || (CntW'(i) == cnt_q)) begin
          row_d[i] = value_i;
        end else begin
          row_d[i] = row_q[i];
        end
      end else if (do_rep) begin
        // drop the smallest, shift smaller entries down, place the value
        if (lt_next[i]) begin
          row_d[i] = row_next[i];
        end else if ((i == 0) || lt[i]) begin
          row_d[i] = value_i;
        end else begin
          row_d[i] = row_q[i];
        end
      end else begin
        row_d[i] = row_q[i];
      end
    end
  end

  // Advance the row on each accepted request
  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      for (int i = 0; i < K_MAX; i++) begin
        row_q[i] <= row_d[i];
      end
    end
  end

  // Update the fill count; empty the row at the end of a set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (upd_en_i) begin
      cnt_q <= last_i ? '0 : cnt_d;
    end
  end

  assign row_d_o = row_d;
  assign cnt_d_o = cnt_d;

endmodule

`default_nettype wire

/* src/kls_pick.sv */
// Selects the k-th largest kept value and holds it in the output register.
`default_nettype none

module kls_pick
  import kls_pkg::*;
#(
  parameter int unsigned K_MAX = 16,
  localparam int unsigned CntW = $clog2(K_MAX + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire value_t          row_i [K_MAX],
  input  wire logic [CntW-1:0] cnt_i,
  input  wire logic [CntW-1:0] k_i,
  input  wire logic            capture_i,
  input  wire logic            out_ready_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  output kls_result_t          out_res_o
);

  logic [CntW-1:0] sel;
  kls_result_t     res_d;
  kls_result_t     res_q;
  logic            valid_q;

  // Index count-k from the bottom of the row; short set takes the minimum
  always_comb begin
    sel             = cnt_i - k_i;
    res_d.short_set = (cnt_i < k_i);
    res_d.kth_value = row_i[0];
    if (!res_d.short_set) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (CntW'(i) == sel) begin
          res_d.kth_value = row_i[i];
        end
      end
    end
  end

  assign free_o = !valid_q || out_ready_i;

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= capture_i;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

/* src/kth_largest_stream_tracker_unit.sv */
// Top level of the streaming k-th largest tracker.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata = value, tlast = last
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata = kth_value, tuser = short_set
//  cfg       in   cfg_we_i                     cfg_wdata_i = rank_k
//
// One request per cycle while s_axis_tready is high; the sorted row compares and shifts combinationally.
// A request with tlast loads the result register at its accepting edge; the
// result is offered on the next cycle.
// Reset empties the row and sets rank_k to one; no clearing pass is needed.
// Input stalls only while a result is waiting and m_axis_tready is low.
`default_nettype none

module kth_largest_stream_tracker_unit
  import kls_pkg::*;
#(
  parameter int unsigned K_MAX = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire rank_t         cfg_wdata_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [31:0]   s_axis_tdata,   // [31:0] value
  input  wire logic          s_axis_tlast,   // last
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [31:0] kth_value
  output logic               m_axis_tuser    // [0] short_set
);

  localparam int unsigned CntW = $clog2(K_MAX + 1);

  rank_t           rank_q;
  logic [CntW-1:0] k_eff;
  logic            accept;
  logic            free;
  value_t          row_d [K_MAX];
  logic [CntW-1:0] cnt_d;
  kls_result_t     out_res;

  // Rank register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= rank_t'(1);
    end else if (cfg_we_i) begin
      rank_q <= cfg_wdata_i;
    end
  end

  // Saturate rank to 1..K_MAX
  always_comb begin
    if (rank_q == '0) begin
      k_eff = CntW'(1);
    end else if (32'(rank_q) > 32'(K_MAX)) begin
      k_eff = CntW'(K_MAX);
    end else begin
      k_eff = CntW'(rank_q);
    end
  end

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  kls_row #(
    .K_MAX (K_MAX)
  ) u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_en_i (accept),
    .value_i  (value_t'(s_axis_tdata)),
    .last_i   (s_axis_tlast),
    .k_i      (k_eff),
    .row_d_o  (row_d),
    .cnt_d_o  (cnt_d)
  );

  kls_pick #(
    .K_MAX (K_MAX)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_i       (row_d),
    .cnt_i       (cnt_d),
    .k_i         (k_eff),
    .capture_i   (accept && s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .free_o      (free),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = 32'(out_res.kth_value);
  assign m_axis_tuser = out_res.short_set;

endmodule

`default_nettype wire
